>>> hdl/scm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scm_pkg
// Shared types and constants for the scalar-to-RGBA color map: pipeline
// control flags, configuration register indexes and the six-color table.
// ----------------------------------------------------------------------------
package scm_pkg;

    // Control flags that travel with each transaction down the pipeline
    typedef struct packed {
        logic valid;
        logic zero;     // position saturates at the first color
        logic one;      // position saturates at the last color
    } t_scm_ctl;

    // Configuration register indexes
    localparam int CFG_INDEX_BITS = 2;
    typedef logic [CFG_INDEX_BITS-1:0] t_cfg_index;
    localparam t_cfg_index REG_RANGE_LOW  = 2'd0;
    localparam t_cfg_index REG_RANGE_HIGH = 2'd1;

    // Color table: white, blue, cyan, green, yellow, red (bit i is color i)
    localparam int NCOLOR   = 6;
    localparam int SEG_BITS = 3;
    typedef logic [SEG_BITS-1:0] t_seg;
    localparam t_seg SEG_FIRST = 3'd1;
    localparam logic [NCOLOR-1:0] TAB_R = 6'b110001;
    localparam logic [NCOLOR-1:0] TAB_G = 6'b011101;
    localparam logic [NCOLOR-1:0] TAB_B = 6'b000111;

endpackage

>>> hdl/scalar_to_rgba_color_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scalar_to_rgba_color_map
// Colors a signed scalar sample on a six-color piecewise linear scale
// (white, blue, cyan, green, yellow, red) over a configured range.
//
//   channel   handshake               payload
//   --------  ----------------------  -----------------------------------
//   command   start / busy            i_sample
//   config    i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//   result    o_valid (strobe)        o_red, o_green, o_blue, o_alpha
//
// A transaction is taken every cycle while busy is low; its result strobes out
// after the front stages, the one-bit-per-stage division that produces the
// normalized position and the output stages. busy is high in reset and in the
// cycle after it. Reset clears both range registers and drops all transactions
// in flight. The result side has no back-pressure, so the pipeline never stalls.
// ----------------------------------------------------------------------------
module scalar_to_rgba_color_map
    import scm_pkg::*;
#(
    parameter int SAMPLE_BITS   = 32,
    parameter int FRACTION_BITS = 16,
    parameter int CHANNEL_BITS  = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [SAMPLE_BITS-1:0]  i_sample,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  t_cfg_index              i_cfg_index,
    input  logic [SAMPLE_BITS-1:0]  i_cfg_data,
    output logic                    o_valid,
    output logic [CHANNEL_BITS-1:0] o_red,
    output logic [CHANNEL_BITS-1:0] o_green,
    output logic [CHANNEL_BITS-1:0] o_blue,
    output logic [CHANNEL_BITS-1:0] o_alpha
);

    logic                     r_busy;
    logic [SAMPLE_BITS-1:0]   r_range_low;
    logic [SAMPLE_BITS-1:0]   r_range_high;
    logic                     w_accept;

    t_scm_ctl                 w_ctl [FRACTION_BITS+1];
    logic [SAMPLE_BITS-1:0]   w_rem [FRACTION_BITS+1];
    logic [SAMPLE_BITS-1:0]   w_div [FRACTION_BITS+1];
    logic [FRACTION_BITS-1:0] w_quo [FRACTION_BITS+1];

    // Hold off commands for the cycle after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy     = r_busy;
    assign w_accept = start && !r_busy;

    // Range registers; unknown indexes drop the write
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_low  <= '0;
            r_range_high <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_RANGE_LOW:  r_range_low  <= i_cfg_data;
                REG_RANGE_HIGH: r_range_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Normalize against the range
    scm_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_sample     (i_sample),
        .i_range_low  (r_range_low),
        .i_range_high (r_range_high),
        .o_ctl        (w_ctl[0]),
        .o_rem        (w_rem[0]),
        .o_div        (w_div[0])
    );

    assign w_quo[0] = '0;

    // Division chain, one quotient bit per stage
    for (genvar g = 0; g < FRACTION_BITS; g++) begin : g_div
        scm_div_step #(
            .SAMPLE_BITS   (SAMPLE_BITS),
            .FRACTION_BITS (FRACTION_BITS)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[g]),
            .i_rem   (w_rem[g]),
            .i_div   (w_div[g]),
            .i_quo   (w_quo[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_div   (w_div[g+1]),
            .o_quo   (w_quo[g+1])
        );
    end

    // Segment lookup and blend
    scm_blend #(
        .FRACTION_BITS (FRACTION_BITS),
        .CHANNEL_BITS  (CHANNEL_BITS)
    ) u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl[FRACTION_BITS]),
        .i_quo   (w_quo[FRACTION_BITS]),
        .o_valid (o_valid),
        .o_red   (o_red),
        .o_green (o_green),
        .o_blue  (o_blue)
    );

    assign o_alpha = '1;

endmodule

>>> hdl/scm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scm_front
// Input stages: register the sample, form numerator and denominator against
// the configured range, fold reversed ranges and flag saturated positions.
// ----------------------------------------------------------------------------
module scm_front
    import scm_pkg::*;
#(
    parameter int SAMPLE_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic [SAMPLE_BITS-1:0] i_range_low,
    input  logic [SAMPLE_BITS-1:0] i_range_high,
    output t_scm_ctl               o_ctl,
    output logic [SAMPLE_BITS-1:0] o_rem,
    output logic [SAMPLE_BITS-1:0] o_div
);

    localparam int W = SAMPLE_BITS + 1;

    logic                   r_a_valid;
    logic [SAMPLE_BITS-1:0] r_a_sample;
    logic                   r_b_valid;
    logic signed [W-1:0]    r_b_num;
    logic signed [W-1:0]    r_b_den;
    logic signed [W-1:0]    n_b_num;
    logic signed [W-1:0]    n_b_den;
    logic                   r_c_valid;
    logic signed [W-1:0]    r_c_num;
    logic signed [W-1:0]    r_c_den;
    logic signed [W-1:0]    n_c_num;
    logic signed [W-1:0]    n_c_den;
    t_scm_ctl               r_d_ctl;
    t_scm_ctl               n_d_ctl;
    logic [SAMPLE_BITS-1:0] r_d_rem;
    logic [SAMPLE_BITS-1:0] r_d_div;

    // Valid bits of the front stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid     <= 1'b0;
            r_b_valid     <= 1'b0;
            r_c_valid     <= 1'b0;
            r_d_ctl.valid <= 1'b0;
        end else begin
            r_a_valid     <= i_accept;
            r_b_valid     <= r_a_valid;
            r_c_valid     <= r_b_valid;
            r_d_ctl.valid <= n_d_ctl.valid;
        end
    end

    // Subtract the low bound from sample and from the high bound
    always_comb begin
        n_b_num = $signed({r_a_sample[SAMPLE_BITS-1], r_a_sample})
                - $signed({i_range_low[SAMPLE_BITS-1], i_range_low});
        n_b_den = $signed({i_range_high[SAMPLE_BITS-1], i_range_high})
                - $signed({i_range_low[SAMPLE_BITS-1], i_range_low});
    end

    // Flip both signs for a reversed range
    always_comb begin
        if (r_b_den[W-1]) begin
            n_c_num = -r_b_num;
            n_c_den = -r_b_den;
        end else begin
            n_c_num = r_b_num;
            n_c_den = r_b_den;
        end
    end

    // Flag positions that saturate at either end
    always_comb begin
        n_d_ctl.valid = r_c_valid;
        n_d_ctl.zero  = (r_c_den == '0) || r_c_num[W-1] || (r_c_num == '0);
        n_d_ctl.one   = !n_d_ctl.zero && (r_c_num >= r_c_den);
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_a_sample   <= i_sample;
        r_b_num      <= n_b_num;
        r_b_den      <= n_b_den;
        r_c_num      <= n_c_num;
        r_c_den      <= n_c_den;
        r_d_ctl.zero <= n_d_ctl.zero;
        r_d_ctl.one  <= n_d_ctl.one;
        r_d_rem      <= r_c_num[SAMPLE_BITS-1:0];
        r_d_div      <= r_c_den[SAMPLE_BITS-1:0];
    end

    assign o_ctl = r_d_ctl;
    assign o_rem = r_d_rem;
    assign o_div = r_d_div;

endmodule

>>> hdl/scm_div_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scm_div_step
// One registered step of the restoring division that yields the normalized
// position: shift the partial remainder, compare, subtract, shift in a bit.
// ----------------------------------------------------------------------------
module scm_div_step
    import scm_pkg::*;
#(
    parameter int SAMPLE_BITS   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_scm_ctl                 i_ctl,
    input  logic [SAMPLE_BITS-1:0]   i_rem,
    input  logic [SAMPLE_BITS-1:0]   i_div,
    input  logic [FRACTION_BITS-1:0] i_quo,
    output t_scm_ctl                 o_ctl,
    output logic [SAMPLE_BITS-1:0]   o_rem,
    output logic [SAMPLE_BITS-1:0]   o_div,
    output logic [FRACTION_BITS-1:0] o_quo
);

    logic [SAMPLE_BITS:0]     w_shift;
    logic [SAMPLE_BITS:0]     w_diff;
    logic                     w_ge;
    logic [SAMPLE_BITS-1:0]   n_rem;
    t_scm_ctl                 r_ctl;
    logic [SAMPLE_BITS-1:0]   r_rem;
    logic [SAMPLE_BITS-1:0]   r_div;
    logic [FRACTION_BITS-1:0] r_quo;

    // Compare and subtract the divisor from the doubled remainder
    always_comb begin
        w_shift = {i_rem, 1'b0};
        w_diff  = w_shift - {1'b0, i_div};
        w_ge    = (w_shift >= {1'b0, i_div});
        n_rem   = w_ge ? w_diff[SAMPLE_BITS-1:0] : w_shift[SAMPLE_BITS-1:0];
    end

    // Advance the valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else begin
            r_ctl.valid <= i_ctl.valid;
        end
    end

    // Hold the step result
    always_ff @(posedge i_clk) begin
        r_ctl.zero <= i_ctl.zero;
        r_ctl.one  <= i_ctl.one;
        r_rem      <= n_rem;
        r_div      <= i_div;
        r_quo      <= {i_quo[FRACTION_BITS-2:0], w_ge};
    end

    assign o_ctl = r_ctl;
    assign o_rem = r_rem;
    assign o_div = r_div;
    assign o_quo = r_quo;

endmodule

>>> hdl/scm_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scm_blend
// Output stages: scale the position by five, pick the segment and its two
// colors, blend each channel by the segment fraction and round to the
// channel width.
// ----------------------------------------------------------------------------
module scm_blend
    import scm_pkg::*;
#(
    parameter int FRACTION_BITS = 16,
    parameter int CHANNEL_BITS  = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_scm_ctl                 i_ctl,
    input  logic [FRACTION_BITS-1:0] i_quo,
    output logic                     o_valid,
    output logic [CHANNEL_BITS-1:0]  o_red,
    output logic [CHANNEL_BITS-1:0]  o_green,
    output logic [CHANNEL_BITS-1:0]  o_blue
);

    localparam int F  = FRACTION_BITS;
    localparam int C  = CHANNEL_BITS;
    localparam int SW = F + 3;       // holds five times one
    localparam int PW = F + C + 1;   // blended value times full scale

    localparam logic [F:0]    ONE  = {1'b1, {F{1'b0}}};
    localparam logic [PW-1:0] HALF = {{(C + 1){1'b0}}, 1'b1, {(F - 1){1'b0}}};
    localparam logic [C:0]    FULL = {1'b0, {C{1'b1}}};

    // Blend two binary color components by the fraction
    function automatic logic [F:0] mix(input logic [1:0] sel, input logic [F:0] frac);
        logic [F:0] res;
        case (sel)
            2'b11:   res = ONE;
            2'b10:   res = ONE - frac;
            2'b01:   res = frac;
            default: res = '0;
        endcase
        return res;
    endfunction

    // Scale to the channel range and round half up
    function automatic logic [C-1:0] scale(input logic [F:0] c);
        logic [PW-1:0] prod;
        logic [C:0]    v;
        prod = {c, {C{1'b0}}} - {{C{1'b0}}, c} + HALF;
        v    = prod[PW-1:F];
        if (v > FULL) begin
            v = FULL;
        end
        return v[C-1:0];
    endfunction

    logic            r_e_valid;
    logic [SW-1:0]   r_e_s;
    logic [F:0]      n_e_t;
    logic [SW-1:0]   n_e_s;
    logic            r_f_valid;
    logic [F:0]      r_f_frac;
    logic [1:0]      r_f_sel_r;
    logic [1:0]      r_f_sel_g;
    logic [1:0]      r_f_sel_b;
    t_seg            n_f_k;
    t_seg            n_f_km1;
    logic [SW-1:0]   n_f_rest;
    logic            r_g_valid;
    logic [F:0]      r_g_r;
    logic [F:0]      r_g_g;
    logic [F:0]      r_g_b;
    logic            r_h_valid;
    logic [C-1:0]    r_h_r;
    logic [C-1:0]    r_h_g;
    logic [C-1:0]    r_h_b;

    // Valid bits of the output stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
            r_f_valid <= 1'b0;
            r_g_valid <= 1'b0;
            r_h_valid <= 1'b0;
        end else begin
            r_e_valid <= i_ctl.valid;
            r_f_valid <= r_e_valid;
            r_g_valid <= r_f_valid;
            r_h_valid <= r_g_valid;
        end
    end

    // Apply saturation and scale the position by five
    always_comb begin
        if (i_ctl.zero) begin
            n_e_t = '0;
        end else if (i_ctl.one) begin
            n_e_t = ONE;
        end else begin
            n_e_t = {1'b0, i_quo};
        end
        n_e_s = {n_e_t, 2'b00} + {2'b00, n_e_t};
    end

    // Pick the segment as the ceiling of the scaled position, at least one
    always_comb begin
        n_f_k = r_e_s[SW-1:F] + {{(SEG_BITS - 1){1'b0}}, |r_e_s[F-1:0]};
        if (n_f_k == '0) begin
            n_f_k = SEG_FIRST;
        end
        n_f_km1  = n_f_k - SEG_FIRST;
        n_f_rest = r_e_s - {n_f_km1, {F{1'b0}}};
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_e_s     <= n_e_s;
        r_f_frac  <= n_f_rest[F:0];
        r_f_sel_r <= {TAB_R[n_f_km1], TAB_R[n_f_k]};
        r_f_sel_g <= {TAB_G[n_f_km1], TAB_G[n_f_k]};
        r_f_sel_b <= {TAB_B[n_f_km1], TAB_B[n_f_k]};
        r_g_r     <= mix(r_f_sel_r, r_f_frac);
        r_g_g     <= mix(r_f_sel_g, r_f_frac);
        r_g_b     <= mix(r_f_sel_b, r_f_frac);
        r_h_r     <= scale(r_g_r);
        r_h_g     <= scale(r_g_g);
        r_h_b     <= scale(r_g_b);
    end

    assign o_valid = r_h_valid;
    assign o_red   = r_h_r;
    assign o_green = r_h_g;
    assign o_blue  = r_h_b;

endmodule

>>> hdl/scm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scm_checker
// Port-level checks of the color map: fixed latency in both directions and
// properties of every color the map can produce.
// ----------------------------------------------------------------------------
module scm_checker #(
    parameter int SAMPLE_BITS   = 32,
    parameter int FRACTION_BITS = 16,
    parameter int CHANNEL_BITS  = 8
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    start,
    input logic                    busy,
    input logic [SAMPLE_BITS-1:0]  i_sample,
    input logic                    o_valid,
    input logic [CHANNEL_BITS-1:0] o_red,
    input logic [CHANNEL_BITS-1:0] o_green,
    input logic [CHANNEL_BITS-1:0] o_blue,
    input logic [CHANNEL_BITS-1:0] o_alpha
);

    localparam int LAT = FRACTION_BITS + 8;

    // Every accepted transaction strobes a result after the fixed latency
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("accepted sample produced no result");

    // No result without a matching accepted transaction
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result strobe without a command");

    // Adjacent colors always share a full channel
    a_full_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_red == '1 || o_green == '1 || o_blue == '1))
        else $error("blended color has no full-scale channel");

    // Alpha stays opaque on every result
    a_alpha_opaque: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_alpha == '1))
        else $error("alpha not full scale");

    // Accepted samples carry only known bits
    a_sample_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> !$isunknown(i_sample))
        else $error("accepted sample carries unknown bits");

endmodule

bind scalar_to_rgba_color_map scm_checker #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS),
    .CHANNEL_BITS  (CHANNEL_BITS)
) u_scm_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_sample (i_sample),
    .o_valid  (o_valid),
    .o_red    (o_red),
    .o_green  (o_green),
    .o_blue   (o_blue),
    .o_alpha  (o_alpha)
);

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Regression for scalar_to_rgba_color_map. A stimulus process walks through
// a series of range settings: default, extreme, reversed, equal, tiny and
// random. Between settings it writes the range registers while the pipeline
// is empty. A clocked driver feeds samples from a queue with random idle
// bursts. A clocked monitor checks every color strobe against an in-order
// queue of colors predicted from the sample and the shadowed range.
// ----------------------------------------------------------------------------
module tb;
    import scm_pkg::*;

    localparam int SAMPLE_W    = 32;
    localparam int FRAC_BITS   = 16;
    localparam int CHAN_W      = 8;
    localparam longint ONE     = longint'(1) << FRAC_BITS;
    localparam longint CHAN_MAX = (longint'(1) << CHAN_W) - 1;
    localparam int SEGMENTS    = NCOLOR - 1;
    localparam int LATENCY     = FRAC_BITS + 8;
    localparam int NUM_PHASES  = 12;
    localparam int ITEMS_PER_PHASE = 161;
    localparam int CYCLE_LIMIT = 200000;

    // Indexes outside the register map; writes to them must be ignored
    localparam t_cfg_index REG_SPARE_2 = 2'd2;
    localparam t_cfg_index REG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
    } t_rgba;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [SAMPLE_W-1:0] i_sample = '0;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    t_cfg_index          i_cfg_index = REG_RANGE_LOW;
    logic [SAMPLE_W-1:0] i_cfg_data = '0;
    logic                o_valid;
    logic [CHAN_W-1:0]   o_red;
    logic [CHAN_W-1:0]   o_green;
    logic [CHAN_W-1:0]   o_blue;
    logic [CHAN_W-1:0]   o_alpha;

    // Shadow copy of the range registers
    logic signed [SAMPLE_W-1:0] range_low_q = '0;
    logic signed [SAMPLE_W-1:0] range_high_q = '0;

    logic [SAMPLE_W-1:0] sample_q[$];
    t_rgba               color_q[$];
    int                  mismatch_count = 0;
    int                  gap_left = 0;
    int                  gap_pct = 0;
    logic                calm = 1'b0;
    int                  cycle_count = 0;

    scalar_to_rgba_color_map dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_sample    (i_sample),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_valid),
        .o_red       (o_red),
        .o_green     (o_green),
        .o_blue      (o_blue),
        .o_alpha     (o_alpha)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Blend two table entries by fraction f and round half up
    function automatic logic [CHAN_W-1:0] blend_channel(logic c0, logic c1, longint f);
        longint mix;
        longint level;
        mix = (c0 ? (ONE - f) : 0) + (c1 ? f : 0);
        level = (mix * CHAN_MAX + (ONE >> 1)) >> FRAC_BITS;
        if (level > CHAN_MAX) begin
            level = CHAN_MAX;
        end
        return level[CHAN_W-1:0];
    endfunction

    // Color of one sample under the current shadowed range
    function automatic t_rgba predict_color(logic signed [SAMPLE_W-1:0] sample);
        longint num;
        longint den;
        longint pos;
        longint scaled;
        longint frac;
        int     seg;
        t_rgba  color;
        num = longint'(sample) - longint'(range_low_q);
        den = longint'(range_high_q) - longint'(range_low_q);
        // Reversed bounds: flip both signs so low still maps to white
        if (den < 0) begin
            den = -den;
            num = -num;
        end
        if (den == 0 || num <= 0) begin
            pos = 0;
        end else if (num >= den) begin
            pos = ONE;
        end else begin
            pos = (num << FRAC_BITS) / den;
        end
        scaled = pos * SEGMENTS;
        seg = int'((scaled + ONE - 1) >> FRAC_BITS);
        if (seg < 1) begin
            seg = 1;
        end
        if (seg > SEGMENTS) begin
            seg = SEGMENTS;
        end
        frac = scaled - longint'(seg - 1) * ONE;
        if (frac > ONE) begin
            frac = ONE;
        end
        color.red   = blend_channel(TAB_R[seg-1], TAB_R[seg], frac);
        color.green = blend_channel(TAB_G[seg-1], TAB_G[seg], frac);
        color.blue  = blend_channel(TAB_B[seg-1], TAB_B[seg], frac);
        color.alpha = CHAN_MAX[CHAN_W-1:0];
        return color;
    endfunction

    // Random sample: mostly inside the range, some outside, some raw
    function automatic logic [SAMPLE_W-1:0] pick_sample(logic signed [SAMPLE_W-1:0] lo,
                                                        logic signed [SAMPLE_W-1:0] hi);
        longint span;
        longint val;
        span = longint'(hi) - longint'(lo);
        case ($urandom_range(0, 9))
            0: val = longint'($urandom);
            1: begin
                case ($urandom_range(0, 5))
                    0: val = -(longint'(1) << (SAMPLE_W - 1));
                    1: val = (longint'(1) << (SAMPLE_W - 1)) - 1;
                    2: val = lo;
                    3: val = hi;
                    4: val = 0;
                    default: val = -1;
                endcase
            end
            2: val = ($urandom_range(0, 1) ? longint'(lo) : longint'(hi))
                     + longint'($urandom_range(0, 2000)) - 1000;
            default: val = longint'(lo)
                           + (span * longint'($urandom_range(0, 65536))) / 65536
                           + longint'($urandom_range(0, 6)) - 3;
        endcase
        return val[SAMPLE_W-1:0];
    endfunction

    // Wait until no sample is queued, in flight or awaiting its color;
    // look at the falling edge so the driver's updates have settled
    task automatic wait_idle();
        while (sample_q.size() != 0 || start || color_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Write one configuration register and hold until it is taken
    task automatic write_cfg(t_cfg_index idx, logic [SAMPLE_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Track accepted register writes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            range_low_q  <= '0;
            range_high_q <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == REG_RANGE_LOW) begin
                range_low_q <= i_cfg_data;
            end else if (i_cfg_index == REG_RANGE_HIGH) begin
                range_high_q <= i_cfg_data;
            end
        end
    end

    // Drive samples from the queue, predicting each accepted transaction
    always @(posedge i_clk) begin : drive_proc
        logic                nxt_start;
        logic [SAMPLE_W-1:0] nxt_sample;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            nxt_start  = start;
            nxt_sample = i_sample;
            if (start && !busy) begin
                color_q.push_back(predict_color(i_sample));
                nxt_start = 1'b0;
            end
            if (!nxt_start) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (sample_q.size() > 0) begin
                    nxt_sample = sample_q.pop_front();
                    nxt_start  = 1'b1;
                    if (!calm && $urandom_range(0, 99) < gap_pct) begin
                        gap_left = $urandom_range(1, 15);
                    end
                end
            end
            start    <= nxt_start;
            i_sample <= nxt_sample;
        end
    end

    // Check each color strobe against the oldest prediction
    always @(posedge i_clk) begin : check_proc
        t_rgba got;
        t_rgba want;
        if (i_rst_n && o_valid) begin
            got = '{red: o_red, green: o_green, blue: o_blue, alpha: o_alpha};
            if (color_q.size() == 0) begin
                $display("%0t: unexpected color r=%0d g=%0d b=%0d a=%0d",
                         $time, got.red, got.green, got.blue, got.alpha);
                mismatch_count++;
            end else begin
                want = color_q.pop_front();
                if (got !== want) begin
                    $display(
                        "%0t: mismatch expected r=%0d g=%0d b=%0d a=%0d actual r=%0d g=%0d b=%0d a=%0d",
                        $time, want.red, want.green, want.blue, want.alpha,
                        got.red, got.green, got.blue, got.alpha);
                    mismatch_count++;
                end
            end
        end
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("scalar_to_rgba_color_map regression: fail");
            $finish;
        end
    end

    initial begin : stim_proc
        logic signed [SAMPLE_W-1:0] lo;
        logic signed [SAMPLE_W-1:0] hi;
        longint                     span;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            case (p)
                0: begin lo = 0; hi = 0; end
                1: begin lo = -1000; hi = 1000; end
                2: begin lo = 32'sh8000_0000; hi = 32'sh7fff_ffff; end
                3: begin lo = 32'sh7fff_ffff; hi = 32'sh8000_0000; end
                4: begin lo = 12345; hi = 12345; end
                5: begin lo = 0; hi = 5; end
                6: begin lo = 300; hi = -300; end
                8: begin lo = $urandom; hi = lo + $urandom_range(1, 40); end
                9: begin lo = $urandom; hi = lo - $urandom_range(1, 100000); end
                default: begin lo = $urandom; hi = $urandom; end
            endcase

            // Reprogram the range; spare indexes must leave it untouched
            if (p > 0) begin
                write_cfg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, $urandom);
                if (p % 2 == 0) begin
                    write_cfg(REG_RANGE_LOW, lo);
                    write_cfg(REG_RANGE_HIGH, hi);
                end else begin
                    write_cfg(REG_RANGE_HIGH, hi);
                    write_cfg(REG_RANGE_LOW, lo);
                end
                write_cfg(REG_SPARE_3, $urandom);
                write_cfg(REG_SPARE_2, $urandom);
            end

            case (p % 3)
                0: gap_pct = 0;
                1: gap_pct = 12;
                default: gap_pct = 35;
            endcase
            calm = (p >= NUM_PHASES - 2);

            // Equal bounds after reset: everything is white
            if (p == 0) begin
                sample_q.push_back(32'h8000_0000);
                sample_q.push_back(32'h7fff_ffff);
                sample_q.push_back(32'h0000_0000);
                sample_q.push_back(32'hffff_ffff);
            end

            // Segment edges and midpoints, the first inner edge +/- 1, and saturation
            if (p == 1) begin
                span = longint'(hi) - longint'(lo);
                for (int j = 0; j <= 10; j++) begin
                    sample_q.push_back(SAMPLE_W'(longint'(lo) + span * j / 10));
                end
                sample_q.push_back(SAMPLE_W'(longint'(lo) + span / 5 - 1));
                sample_q.push_back(SAMPLE_W'(longint'(lo) + span / 5 + 1));
                sample_q.push_back(SAMPLE_W'(longint'(lo) - 1));
                sample_q.push_back(SAMPLE_W'(longint'(hi) + 1));
                sample_q.push_back(32'h8000_0000);
                sample_q.push_back(32'h7fff_ffff);
            end

            repeat (ITEMS_PER_PHASE) sample_q.push_back(pick_sample(lo, hi));
        end

        wait_idle();
        repeat (LATENCY + 8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("scalar_to_rgba_color_map regression: pass");
        end else begin
            $display("scalar_to_rgba_color_map regression: fail");
        end
        $finish;
    end

endmodule
